>>> hw/rtl/hvr_pkg.sv
// ----------------------------------------------------------------------------
// hvr_pkg
// Shared types and constants for the real Householder vector unit.
// ----------------------------------------------------------------------------
package hvr_pkg;

  // vector store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // arithmetic widths
  localparam int SUM_W  = 38;   // sum of squares
  localparam int SQ_W   = 56;   // square-root operand (even)
  localparam int RT_W   = SQ_W / 2;
  localparam int SMAG_W = 27;   // new first element magnitude, 8 fraction bits
  localparam int DIV_W  = 46;   // divider remainder width
  localparam int QB     = 16;   // quotient bits

  localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
  localparam logic [15:0] Q15_POS_MAX = 16'h7FFF;
  localparam logic [15:0] Q15_NEG_MAX = 16'h8000;

  typedef struct packed {
    logic signed [15:0] element;
    logic               last;
  } hvr_in_t;

  typedef struct packed {
    logic signed [15:0] unit_element;
    logic               final_res;
  } hvr_out_t;

  // divider request
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] num;
    logic [RT_W:0]    den;
  } hvr_div_req_t;

endpackage

>>> hw/rtl/householder_vector_real_unit.sv
// ----------------------------------------------------------------------------
// householder_vector_real_unit
// Builds a Q1.15 unit Householder vector from a stored real vector.
// ----------------------------------------------------------------------------
// Input words (in_valid / in_stall / in_word) carry one 16-bit element each;
// the word with last set closes the vector. Up to DEPTH elements are kept,
// further ones are dropped, though their last flag still closes the vector.
// While loading, one word is taken per cycle.
// After the last word the unit stalls its input and works alone: two
// iterative square roots with setup steps between them, then for every
// element one store read, a divide (skipped when the root is zero) and one
// output word (out_valid / out_stall / out_word), final_res set on the last
// one. The divider sets the time per element, along with any receiver stall.
// A stalled output word is held in its register until taken; nothing moves
// meanwhile. After the final word the unit returns to loading.
// Reset (rst_n low, synchronous) clears the count, sum and control; the
// store needs no clearing since only entries of the current vector are read.
// ----------------------------------------------------------------------------
module householder_vector_real_unit import hvr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hvr_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output hvr_out_t out_word
);

  typedef enum logic [2:0] {
    S_LOAD, S_ROOT1, S_SQR, S_TSUM, S_ROOT2, S_READ, S_CALC, S_DIV
  } state_t;

  state_t              state_r;
  logic                out_valid_r;
  hvr_out_t            out_word_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    count_r;
  logic [15:0]         x0_mag_r;
  logic                x0_neg_r;
  logic [30:0]         x0_sq_r;
  logic [SMAG_W-1:0]   s_mag_r;
  logic [2*SMAG_W-1:0] ssq_r;
  logic [RT_W-1:0]     m8_r;
  logic [ADDR_W-1:0]   idx_r;

  logic signed [15:0]  mem [DEPTH];
  logic signed [15:0]  rd_data_r;

  logic                in_acc, store_en, rd_en, is_final;
  logic [15:0]         x_mag, rd_mag;
  logic [30:0]         x_sq;
  logic [SUM_W-1:0]    sum_nxt;
  logic                sq_start, sq_done;
  logic [SQ_W-1:0]     sq_op;
  logic [RT_W-1:0]     sq_root;
  hvr_div_req_t        div_req;
  logic                div_done;
  logic [15:0]         div_res;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign store_en  = in_acc && (count_r < CNT_W'(DEPTH));
  assign x_mag     = in_word.element[15] ? 16'(-in_word.element) : in_word.element;
  assign x_sq      = {15'b0, x_mag} * {15'b0, x_mag};
  assign sum_nxt   = store_en ? sum_r + SUM_W'(x_sq) : sum_r;
  assign rd_mag    = rd_data_r[15] ? 16'(-rd_data_r) : rd_data_r;
  assign is_final  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign rd_en     = (state_r == S_READ);

  // start a root on the last word, and again on the changed squared norm
  assign sq_start = (in_acc && in_word.last) || (state_r == S_TSUM);
  assign sq_op    = (state_r == S_LOAD) ? SQ_W'({sum_nxt, 16'b0})
                  : SQ_W'({sum_r - SUM_W'(x0_sq_r), 16'b0}) + SQ_W'(ssq_r);

  // issue a divide for the element just read
  always_comb begin
    div_req.start = (state_r == S_CALC) && (m8_r != '0);
    div_req.den   = {m8_r, 1'b0};
    if (idx_r == '0) begin
      div_req.neg = x0_neg_r;
      div_req.num = DIV_W'({s_mag_r, 16'b0}) + DIV_W'(m8_r);
    end else begin
      div_req.neg = rd_data_r[15];
      div_req.num = DIV_W'({rd_mag, 24'b0}) + DIV_W'(m8_r);
    end
  end

  hvr_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_op),
    .done    (sq_done),
    .root    (sq_root)
  );

  hvr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .done   (div_done),
    .result (div_res)
  );

  // vector store
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[count_r[ADDR_W-1:0]] <= in_word.element;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // hold the first element's magnitude, sign and square
  always_ff @(posedge clk) begin
    if (store_en && count_r == '0) begin
      x0_mag_r <= x_mag;
      x0_neg_r <= in_word.element[15];
      x0_sq_r  <= x_sq;
    end
  end

  // control sequence and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      idx_r       <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            sum_r <= sum_nxt;
            if (store_en) begin
              count_r <= count_r + 1'b1;
            end
            if (in_word.last) begin
              state_r <= S_ROOT1;
            end
          end
        end
        S_ROOT1: begin
          if (sq_done) begin
            s_mag_r <= SMAG_W'({x0_mag_r, 8'b0}) + SMAG_W'(sq_root);
            state_r <= S_SQR;
          end
        end
        S_SQR: begin
          ssq_r   <= s_mag_r * s_mag_r;
          state_r <= S_TSUM;
        end
        S_TSUM: begin
          state_r <= S_ROOT2;
        end
        S_ROOT2: begin
          if (sq_done) begin
            m8_r    <= sq_root;
            idx_r   <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (!out_valid_r) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (m8_r == '0) begin
            out_word_r.unit_element <= (idx_r == '0) ? Q15_POS_MAX : rd_data_r;
            out_word_r.final_res    <= is_final;
            out_valid_r             <= 1'b1;
            state_r                 <= S_DIV;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_word_r.unit_element <= div_res;
            out_word_r.final_res    <= is_final;
            out_valid_r             <= 1'b1;
          end
          // drop the taken word, then step on
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
            if (out_word_r.final_res) begin
              sum_r   <= '0;
              count_r <= '0;
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_no_out_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("output word valid while loading");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count beyond store depth");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_word.final_res |=> !in_stall && count_r == '0)
    else $error("unit did not return to loading after final word");

  a_last_leaves_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.last |=> in_stall)
    else $error("last word did not close the vector");
`endif

endmodule

>>> hw/rtl/hvr_sqrt.sv
// ----------------------------------------------------------------------------
// hvr_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module hvr_sqrt import hvr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] operand,
  output logic            done,
  output logic [RT_W-1:0] root
);

  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] v_r, r_r, bit_r;
  logic [SQ_W-1:0] trial;

  assign trial = r_r + bit_r;

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // advance one root bit
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= operand;
      r_r   <= '0;
      bit_r <= SQ_BIT_INIT;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[RT_W-1:0];

endmodule

>>> hw/rtl/hvr_div.sv
// ----------------------------------------------------------------------------
// hvr_div
// Restoring divider, one quotient bit per cycle, with Q1.15 saturation.
// ----------------------------------------------------------------------------
module hvr_div import hvr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hvr_div_req_t req,
  output logic         done,
  output logic [15:0]  result
);

  logic               busy_r, done_r, sat_r, neg_r;
  logic [DIV_W-1:0]   rem_r, dsh_r;
  logic [QB-1:0]      q_r;
  logic [$clog2(QB)-1:0] cnt_r;
  logic [DIV_W-1:0]   den_full;

  assign den_full = DIV_W'(req.den) << QB;

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // advance one quotient bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsh_r <= DIV_W'(req.den) << (QB - 1);
      sat_r <= req.num >= den_full;
      neg_r <= req.neg;
      cnt_r <= '1;
      q_r   <= '0;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QB-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QB-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // saturate and apply sign
  always_comb begin
    if (neg_r) begin
      result = (sat_r || q_r > Q15_NEG_MAX) ? Q15_NEG_MAX : 16'(-q_r);
    end else begin
      result = (sat_r || q_r > Q15_POS_MAX) ? Q15_POS_MAX : q_r;
    end
  end

  assign done = done_r;

endmodule
